// ----- hdl/tlpc_pkg.sv -----
package tlpc_pkg;

  localparam int unsigned ScreenWidthDef  = 384;
  localparam int unsigned ScreenHeightDef = 256;
  localparam int unsigned TileCountDef    = 16384;

  localparam int unsigned MapAw  = 12;
  localparam int unsigned RowAw  = 17;
  localparam int unsigned PalAw  = 8;
  localparam int unsigned CodeW  = 14;

  localparam logic [8:0] BeamOrigin = 9'd64;

  typedef enum logic [2:0] {
    FUNC_RENDER    = 3'd0,
    FUNC_BACK_MAP  = 3'd1,
    FUNC_FRONT_MAP = 3'd2,
    FUNC_TILE_ROW  = 3'd3,
    FUNC_PALETTE   = 3'd4
  } func_e;

  typedef enum logic [2:0] {
    CFG_SCROLL_H    = 3'd0,
    CFG_SCROLL_V    = 3'd1,
    CFG_TWO_LAYERS  = 3'd2,
    CFG_DISPLAY_ON  = 3'd3,
    CFG_FLIP_SCREEN = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [15:0] scroll_h;
    logic [15:0] scroll_v;
    logic        two_layers;
    logic        display_on;
    logic        flip_screen;
  } cfg_t;

  typedef struct packed {
    func_e       func;
    logic        render;
    logic [16:0] addr;
    logic [31:0] wdata;
    logic [8:0]  out_x;
    logic [7:0]  out_y;
    logic [8:0]  map_x;
    logic [8:0]  map_y;
  } item_t;

  typedef struct packed {
    logic [13:0] code;
    logic [13:0] quot;
    logic [2:0]  bitsel;
    logic [2:0]  ty;
    logic [3:0]  colour;
    logic [1:0]  group;
  } layer_t;

  typedef struct packed {
    logic       render;
    logic [8:0] out_x;
    logic [7:0] out_y;
    logic       drawn;
  } result_t;

endpackage

// ----- hdl/tlpc_map_fetch.sv -----
module tlpc_map_fetch (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  tlpc_pkg::item_t    item_i,
  output logic               vld_o,
  output tlpc_pkg::item_t    item_o,
  output logic [31:0]        back_entry_o,
  output logic [31:0]        front_entry_o
);

  logic [31:0] back_mem  [2**tlpc_pkg::MapAw];
  logic [31:0] front_mem [2**tlpc_pkg::MapAw];

  logic [tlpc_pkg::MapAw-1:0] rd_idx;
  logic [tlpc_pkg::MapAw-1:0] wr_idx;
  logic                       vld_q;
  tlpc_pkg::item_t            item_q;
  logic [31:0]                back_q;
  logic [31:0]                front_q;

  assign rd_idx = {item_i.map_y[8:3], item_i.map_x[8:3]};
  assign wr_idx = item_i.addr[tlpc_pkg::MapAw-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (vld_i && item_i.func == tlpc_pkg::FUNC_BACK_MAP) begin
        back_mem[wr_idx] <= item_i.wdata;
      end
      if (vld_i && item_i.func == tlpc_pkg::FUNC_FRONT_MAP) begin
        front_mem[wr_idx] <= item_i.wdata;
      end
      back_q  <= back_mem[rd_idx];
      front_q <= front_mem[rd_idx];
      item_q  <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  assign vld_o         = vld_q;
  assign item_o        = item_q;
  assign back_entry_o  = back_q;
  assign front_entry_o = front_q;

endmodule

// ----- hdl/tlpc_tile_fetch.sv -----
module tlpc_tile_fetch #(
  parameter int unsigned NUM_TILES = tlpc_pkg::TileCountDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  tlpc_pkg::item_t    item_i,
  input  logic [31:0]        back_entry_i,
  input  logic [31:0]        front_entry_i,
  output logic               vld_o,
  output tlpc_pkg::item_t    item_o,
  output tlpc_pkg::layer_t   back_o,
  output tlpc_pkg::layer_t   front_o,
  output logic [31:0]        back_row_o,
  output logic [31:0]        front_row_o
);

  // code mod NUM_TILES via reciprocal; estimate is low by at most one
  localparam int unsigned  RecipShift = 28;
  localparam logic [28:0]  Recip      = 29'((64'd1 << RecipShift) / NUM_TILES);
  localparam logic [14:0]  TileCnt    = 15'(NUM_TILES);

  function automatic tlpc_pkg::layer_t decode(logic [31:0] e, logic [8:0] mx, logic [8:0] my);
    tlpc_pkg::layer_t l;
    l.code   = e[13:0];
    l.quot   = '0;
    l.bitsel = e[14] ? mx[2:0] : ~mx[2:0];
    l.ty     = e[15] ? ~my[2:0] : my[2:0];
    l.colour = e[19:16];
    l.group  = e[23:22];
    return l;
  endfunction

  function automatic logic [13:0] reduce(logic [13:0] code, logic [13:0] quot);
    logic [28:0] prod;
    logic [15:0] diff;
    prod = 29'(quot) * 29'(TileCnt);
    diff = {2'b00, code} - prod[15:0];
    if (diff >= {1'b0, TileCnt}) begin
      diff = diff - {1'b0, TileCnt};
    end
    return diff[13:0];
  endfunction

  tlpc_pkg::layer_t back_d, front_d;
  logic [42:0]      back_prod, front_prod;

  logic             vld3_q;
  tlpc_pkg::item_t  item3_q;
  tlpc_pkg::layer_t back3_q, front3_q;

  logic             vld4_q;
  tlpc_pkg::item_t  item4_q;
  tlpc_pkg::layer_t back4_q, front4_q;
  logic [31:0]      back_row_q, front_row_q;

  logic [31:0] row_mem [2**tlpc_pkg::RowAw];

  logic [tlpc_pkg::RowAw-1:0] back_addr, front_addr, wr_addr;

  always_comb begin
    back_d     = decode(back_entry_i, item_i.map_x, item_i.map_y);
    front_d    = decode(front_entry_i, item_i.map_x, item_i.map_y);
    back_prod  = 43'(back_d.code) * 43'(Recip);
    front_prod = 43'(front_d.code) * 43'(Recip);
    back_d.quot  = back_prod[RecipShift +: tlpc_pkg::CodeW];
    front_d.quot = front_prod[RecipShift +: tlpc_pkg::CodeW];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item3_q  <= item_i;
      back3_q  <= back_d;
      front3_q <= front_d;
    end
  end

  assign back_addr  = {reduce(back3_q.code, back3_q.quot), back3_q.ty};
  assign front_addr = {reduce(front3_q.code, front3_q.quot), front3_q.ty};
  assign wr_addr    = item3_q.addr;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (vld3_q && item3_q.func == tlpc_pkg::FUNC_TILE_ROW) begin
        row_mem[wr_addr] <= item3_q.wdata;
      end
      back_row_q  <= row_mem[back_addr];
      front_row_q <= row_mem[front_addr];
      item4_q     <= item3_q;
      back4_q     <= back3_q;
      front4_q    <= front3_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
    end else if (en_i) begin
      vld3_q <= vld_i;
      vld4_q <= vld3_q;
    end
  end

  assign vld_o       = vld4_q;
  assign item_o      = item4_q;
  assign back_o      = back4_q;
  assign front_o     = front4_q;
  assign back_row_o  = back_row_q;
  assign front_row_o = front_row_q;

endmodule

// ----- hdl/tlpc_pixel_mix.sv -----
module tlpc_pixel_mix (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  tlpc_pkg::cfg_t     cfg_i,
  input  logic               vld_i,
  input  tlpc_pkg::item_t    item_i,
  input  tlpc_pkg::layer_t   back_i,
  input  tlpc_pkg::layer_t   front_i,
  input  logic [31:0]        back_row_i,
  input  logic [31:0]        front_row_i,
  output logic               vld_o,
  output tlpc_pkg::result_t  res_o,
  output logic [14:0]        colour_o
);

  function automatic logic [15:0] low_mask(logic front, logic [1:0] grp);
    logic [15:0] m;
    case (grp)
      2'd0:    m = front ? 16'h0001 : 16'h0000;
      2'd1:    m = front ? 16'hFF01 : 16'hFF00;
      default: m = front ? 16'hFFFF : 16'hFFFE;
    endcase
    return m;
  endfunction

  function automatic logic [15:0] high_mask(logic [1:0] grp);
    logic [15:0] m;
    case (grp)
      2'd0:    m = 16'hFFFF;
      2'd1:    m = 16'h00FF;
      default: m = 16'h0001;
    endcase
    return m;
  endfunction

  function automatic logic [3:0] planar(logic [31:0] row, logic [2:0] b);
    logic [3:0] p;
    for (int i = 0; i < 4; i++) begin
      p[i] = row[{i[1:0], b}];
    end
    return p;
  endfunction

  logic [3:0]  pix_b, pix_f;
  logic [15:0] m_bl, m_fl, m_bh, m_fh;
  logic        bl, fl, bh, fh, any, sel_front;
  logic [7:0]  pal_idx;
  logic [14:0] pal_mem [2**tlpc_pkg::PalAw];
  logic [14:0] pal_q;
  logic        vld_q;
  tlpc_pkg::result_t res_d, res_q;

  always_comb begin
    pix_b     = planar(back_row_i, back_i.bitsel);
    pix_f     = planar(front_row_i, front_i.bitsel);
    m_bl      = low_mask(1'b0, back_i.group);
    m_fl      = low_mask(1'b1, front_i.group);
    m_bh      = high_mask(back_i.group);
    m_fh      = high_mask(front_i.group);
    bl        = !m_bl[pix_b];
    fl        = cfg_i.two_layers && !m_fl[pix_f];
    bh        = !m_bh[pix_b];
    fh        = cfg_i.two_layers && !m_fh[pix_f];
    any       = bl || fl || bh || fh;
    sel_front = fh || (!bh && fl);
    pal_idx   = sel_front ? {front_i.colour, pix_f} : {back_i.colour, pix_b};
    res_d.render = item_i.render;
    res_d.out_x  = item_i.out_x;
    res_d.out_y  = item_i.out_y;
    res_d.drawn  = cfg_i.display_on && any;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (vld_i && item_i.func == tlpc_pkg::FUNC_PALETTE) begin
        pal_mem[item_i.addr[tlpc_pkg::PalAw-1:0]] <= item_i.wdata[14:0];
      end
      pal_q <= pal_mem[pal_idx];
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  assign vld_o    = vld_q;
  assign res_o    = res_q;
  assign colour_o = res_q.drawn ? pal_q : 15'd0;

endmodule

// ----- hdl/tile_layer_pixel_compositor.sv -----
// Two-layer tilemap pixel generator, five register stages.
// An accepted item passes the input, map fetch, tile fetch and pixel mix registers in turn.
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// Limiting path: one read from each map store, two tile row reads, one palette read per cycle.
// Reset clears valid bits and config (two_layers, display_on set); stores are
// undefined until written.
module tile_layer_pixel_compositor #(
  parameter int unsigned SCREEN_WIDTH  = tlpc_pkg::ScreenWidthDef,
  parameter int unsigned SCREEN_HEIGHT = tlpc_pkg::ScreenHeightDef,
  parameter int unsigned NUM_TILES     = tlpc_pkg::TileCountDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_addr_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // addr[16:0], wdata[48:17], pos_x[57:49], line[65:58], rscroll[81:66], zero[87:82]
  input  logic [87:0] s_axis_tdata_i,
  // func[2:0]
  input  logic [2:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // out_x[8:0], out_y[16:9], rgb[40:17], zero[47:41]
  output logic [47:0] m_axis_tdata_o,
  // drawn[0]
  output logic [0:0]  m_axis_tuser_o
);

  localparam logic [9:0] ScrW = 10'(SCREEN_WIDTH);
  localparam logic [9:0] ScrH = 10'(SCREEN_HEIGHT);

  tlpc_pkg::cfg_t    cfg_q;
  logic              en;
  logic              out_vld;

  logic [16:0]       in_addr;
  logic [31:0]       in_wdata;
  logic [8:0]        in_x;
  logic [7:0]        in_line;
  logic [15:0]       in_rs;
  logic [9:0]        flip_x, flip_y;
  tlpc_pkg::item_t   s1_d, s1_q;
  logic              s1_vld_q;

  logic              s2_vld;
  tlpc_pkg::item_t   s2_item;
  logic [31:0]       s2_back, s2_front;

  logic              s4_vld;
  tlpc_pkg::item_t   s4_item;
  tlpc_pkg::layer_t  s4_back, s4_front;
  logic [31:0]       s4_back_row, s4_front_row;

  logic              s5_vld;
  tlpc_pkg::result_t s5_res;
  logic [14:0]       s5_colour;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scroll_h    <= '0;
      cfg_q.scroll_v    <= '0;
      cfg_q.two_layers  <= 1'b1;
      cfg_q.display_on  <= 1'b1;
      cfg_q.flip_screen <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (tlpc_pkg::cfg_reg_e'(cfg_addr_i))
        tlpc_pkg::CFG_SCROLL_H:    cfg_q.scroll_h    <= cfg_wdata_i;
        tlpc_pkg::CFG_SCROLL_V:    cfg_q.scroll_v    <= cfg_wdata_i;
        tlpc_pkg::CFG_TWO_LAYERS:  cfg_q.two_layers  <= cfg_wdata_i[0];
        tlpc_pkg::CFG_DISPLAY_ON:  cfg_q.display_on  <= cfg_wdata_i[0];
        tlpc_pkg::CFG_FLIP_SCREEN: cfg_q.flip_screen <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign out_vld         = s5_vld && s5_res.render;
  assign en              = !out_vld || m_axis_tready_i;
  assign s_axis_tready_o = en;

  assign in_addr  = s_axis_tdata_i[16:0];
  assign in_wdata = s_axis_tdata_i[48:17];
  assign in_x     = s_axis_tdata_i[57:49];
  assign in_line  = s_axis_tdata_i[65:58];
  assign in_rs    = s_axis_tdata_i[81:66];

  assign flip_x = ScrW - 10'd1 - {1'b0, in_x};
  assign flip_y = ScrH - 10'd1 - {2'b00, in_line};

  always_comb begin
    s1_d.func     = tlpc_pkg::func_e'(s_axis_tuser_i);
    s1_d.render   = (s1_d.func == tlpc_pkg::FUNC_RENDER) && ({1'b0, in_x} < ScrW)
                    && ({2'b00, in_line} < ScrH);
    s1_d.addr     = in_addr;
    s1_d.wdata    = in_wdata;
    s1_d.out_x    = cfg_q.flip_screen ? flip_x[8:0] : in_x;
    s1_d.out_y    = cfg_q.flip_screen ? flip_y[7:0] : in_line;
    s1_d.map_x    = in_x + tlpc_pkg::BeamOrigin + cfg_q.scroll_h[8:0] + in_rs[8:0];
    s1_d.map_y    = {1'b0, in_line} + cfg_q.scroll_v[8:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q <= s1_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= s_axis_tvalid_i;
    end
  end

  tlpc_map_fetch u_map_fetch (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .vld_i         (s1_vld_q),
    .item_i        (s1_q),
    .vld_o         (s2_vld),
    .item_o        (s2_item),
    .back_entry_o  (s2_back),
    .front_entry_o (s2_front)
  );

  tlpc_tile_fetch #(
    .NUM_TILES (NUM_TILES)
  ) u_tile_fetch (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .vld_i         (s2_vld),
    .item_i        (s2_item),
    .back_entry_i  (s2_back),
    .front_entry_i (s2_front),
    .vld_o         (s4_vld),
    .item_o        (s4_item),
    .back_o        (s4_back),
    .front_o       (s4_front),
    .back_row_o    (s4_back_row),
    .front_row_o   (s4_front_row)
  );

  tlpc_pixel_mix u_pixel_mix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .cfg_i       (cfg_q),
    .vld_i       (s4_vld),
    .item_i      (s4_item),
    .back_i      (s4_back),
    .front_i     (s4_front),
    .back_row_i  (s4_back_row),
    .front_row_i (s4_front_row),
    .vld_o       (s5_vld),
    .res_o       (s5_res),
    .colour_o    (s5_colour)
  );

  assign m_axis_tvalid_o = out_vld;
  assign m_axis_tdata_o  = {7'd0,
                            s5_colour[14:10], s5_colour[14:12],
                            s5_colour[9:5],   s5_colour[9:7],
                            s5_colour[4:0],   s5_colour[4:2],
                            s5_res.out_y, s5_res.out_x};
  assign m_axis_tuser_o  = s5_res.drawn;

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("input accepted while result stalled");

  a_x_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> {1'b0, m_axis_tdata_o[8:0]} < ScrW)
    else $error("output column off screen");

  a_undrawn_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |-> m_axis_tdata_o[40:17] == 24'd0)
    else $error("undrawn pixel not black");

  a_display_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !cfg_q.display_on |-> !m_axis_tuser_o[0])
    else $error("pixel drawn with display off");

endmodule
